[src/rhsv_pkg.sv]
// Shared widths, payload types and the divider step for the RGB to HSV core.
package rhsv_pkg;

    localparam int CHANNEL_BITS = 16;
    // hue numerator t lies below 6 * full scale, so three extra bits
    localparam int T_W   = CHANNEL_BITS + 3;
    localparam int DEN_W = T_W;
    localparam int NUM_W = T_W + CHANNEL_BITS;
    localparam int Q_W   = CHANNEL_BITS;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] hue;
        logic [CHANNEL_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0] brightness;
    } t_hsv;

    // Operands handed from the front end to the divider lanes
    typedef struct packed {
        logic [NUM_W-1:0]        hue_num;
        logic [DEN_W-1:0]        hue_den;
        logic [NUM_W-1:0]        sat_num;
        logic [DEN_W-1:0]        sat_den;
        logic [CHANNEL_BITS-1:0] value;
        logic                    gray;
    } t_div_in;

    // One restoring step: shift in a numerator bit, subtract if it fits.
    // Returns {quotient bit, new remainder}; remainder stays below den.
    function automatic logic [DEN_W:0] div_step(
        input logic [DEN_W-1:0] rem,
        input logic             nb,
        input logic [DEN_W-1:0] den
    );
        logic [DEN_W:0] s;
        logic [DEN_W:0] d;
        logic [DEN_W:0] diff;
        s    = {rem, nb};
        d    = {1'b0, den};
        diff = s - d;
        if (s >= d) begin
            return {1'b1, diff[DEN_W-1:0]};
        end
        return {1'b0, s[DEN_W-1:0]};
    endfunction

endpackage

[src/rhsv_front.sv]
// Front end: max/min, chroma, hue sector and the two division operands.
module rhsv_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  rhsv_pkg::t_rgb    i_pix,
    output logic              o_valid,
    output rhsv_pkg::t_div_in o_div
);
    import rhsv_pkg::*;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    localparam int W = CHANNEL_BITS;

    logic [4:0] r_vld;

    // stage 1
    t_rgb           r_s1_pix;
    logic [W-1:0]   r_s1_max, r_s1_min;
    logic [W-1:0]   n_s1_max, n_s1_min, s_mx_rg, s_mn_rg;
    // stage 2
    logic [W-1:0]   r_s2_max, r_s2_c, n_s2_c;
    logic [W:0]     r_s2_d, n_s2_d;
    t_sector        r_s2_sec, n_s2_sec;
    // stage 3
    logic [W-1:0]   r_s3_max, r_s3_c;
    logic [T_W:0]   r_s3_t0, n_s3_t0;
    logic [T_W-1:0] r_s3_c6, n_s3_c6, s_c_ext, s_base;
    // stage 4
    logic [W-1:0]   r_s4_max, r_s4_c;
    logic [T_W-1:0] r_s4_t, r_s4_c6, n_s4_t;
    logic [T_W:0]   s_wrap;
    // stage 5
    t_div_in        r_s5, n_s5;
    logic [2*W-1:0] s_sat_num;

    always_comb begin
        s_mx_rg  = (i_pix.green > i_pix.red) ? i_pix.green : i_pix.red;
        n_s1_max = (i_pix.blue > s_mx_rg) ? i_pix.blue : s_mx_rg;
        s_mn_rg  = (i_pix.green < i_pix.red) ? i_pix.green : i_pix.red;
        n_s1_min = (i_pix.blue < s_mn_rg) ? i_pix.blue : s_mn_rg;
    end

    always_comb begin
        n_s2_c = r_s1_max - r_s1_min;
        if (r_s1_pix.red == r_s1_max) begin
            n_s2_sec = SEC_RED;
            n_s2_d   = {1'b0, r_s1_pix.green} - {1'b0, r_s1_pix.blue};
        end else if (r_s1_pix.green == r_s1_max) begin
            n_s2_sec = SEC_GREEN;
            n_s2_d   = {1'b0, r_s1_pix.blue} - {1'b0, r_s1_pix.red};
        end else begin
            n_s2_sec = SEC_BLUE;
            n_s2_d   = {1'b0, r_s1_pix.red} - {1'b0, r_s1_pix.green};
        end
    end

    always_comb begin
        s_c_ext = T_W'(r_s2_c);
        unique case (r_s2_sec)
            SEC_RED:   s_base = '0;
            SEC_GREEN: s_base = s_c_ext << 1;
            SEC_BLUE:  s_base = s_c_ext << 2;
            default:   s_base = '0;
        endcase
        // signed sum; the diff is sign extended into the wider word
        n_s3_t0 = {1'b0, s_base} + {{(T_W-W){r_s2_d[W]}}, r_s2_d};
        n_s3_c6 = (s_c_ext << 2) + (s_c_ext << 1);
    end

    always_comb begin
        s_wrap = r_s3_t0 + {1'b0, r_s3_c6};
        n_s4_t = r_s3_t0[T_W] ? s_wrap[T_W-1:0] : r_s3_t0[T_W-1:0];
    end

    always_comb begin
        // x * full scale as (x << W) - x
        s_sat_num       = {r_s4_c, {W{1'b0}}} - (2*W)'(r_s4_c);
        n_s5.hue_num    = {r_s4_t, {W{1'b0}}} - NUM_W'(r_s4_t);
        n_s5.hue_den    = r_s4_c6;
        n_s5.sat_num    = NUM_W'(s_sat_num);
        n_s5.sat_den    = DEN_W'(r_s4_max);
        n_s5.value      = r_s4_max;
        n_s5.gray       = (r_s4_c == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_pix <= i_pix;
            r_s1_max <= n_s1_max;
            r_s1_min <= n_s1_min;
            r_s2_max <= r_s1_max;
            r_s2_c   <= n_s2_c;
            r_s2_d   <= n_s2_d;
            r_s2_sec <= n_s2_sec;
            r_s3_max <= r_s2_max;
            r_s3_c   <= r_s2_c;
            r_s3_t0  <= n_s3_t0;
            r_s3_c6  <= n_s3_c6;
            r_s4_max <= r_s3_max;
            r_s4_c   <= r_s3_c;
            r_s4_t   <= n_s4_t;
            r_s4_c6  <= r_s3_c6;
            r_s5     <= n_s5;
        end
    end

    assign o_valid = r_vld[4];
    assign o_div   = r_s5;

`ifndef SYNTHESIS
    a_hue_num_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && r_s4_c != '0) |-> (r_s4_t < r_s4_c6))
        else $error("hue numerator not below six times chroma");
`endif

endmodule

[src/rhsv_div.sv]
// Two-lane pipelined restoring divider, one quotient bit per stage.
module rhsv_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  rhsv_pkg::t_div_in i_div,
    output logic              o_valid,
    output rhsv_pkg::t_hsv    o_hsv
);
    import rhsv_pkg::*;

    localparam int W = CHANNEL_BITS;

    typedef struct packed {
        logic [DEN_W-1:0] rem_h;
        logic [DEN_W-1:0] den_h;
        logic [W-1:0]     low_h;
        logic [W-1:0]     q_h;
        logic [DEN_W-1:0] rem_s;
        logic [DEN_W-1:0] den_s;
        logic [W-1:0]     low_s;
        logic [W-1:0]     q_s;
        logic [W-1:0]     value;
        logic             gray;
    } t_div_st;

    logic [Q_W-1:0] r_vld;
    t_div_st        r_st  [Q_W];
    t_div_st        n_st  [Q_W];
    t_div_st        s_src [Q_W];

    always_comb begin
        // upper numerator bits are already below the divisor
        s_src[0].rem_h = i_div.hue_num[NUM_W-1:W];
        s_src[0].den_h = i_div.hue_den;
        s_src[0].low_h = i_div.hue_num[W-1:0];
        s_src[0].q_h   = '0;
        s_src[0].rem_s = i_div.sat_num[NUM_W-1:W];
        s_src[0].den_s = i_div.sat_den;
        s_src[0].low_s = i_div.sat_num[W-1:0];
        s_src[0].q_s   = '0;
        s_src[0].value = i_div.value;
        s_src[0].gray  = i_div.gray;
        for (int k = 1; k < Q_W; k++) begin
            s_src[k] = r_st[k-1];
        end
    end

    always_comb begin
        logic [DEN_W:0] sh;
        logic [DEN_W:0] ss;
        for (int k = 0; k < Q_W; k++) begin
            sh = div_step(s_src[k].rem_h, s_src[k].low_h[W-1], s_src[k].den_h);
            ss = div_step(s_src[k].rem_s, s_src[k].low_s[W-1], s_src[k].den_s);
            n_st[k]       = s_src[k];
            n_st[k].rem_h = sh[DEN_W-1:0];
            n_st[k].q_h   = {s_src[k].q_h[W-2:0], sh[DEN_W]};
            n_st[k].low_h = {s_src[k].low_h[W-2:0], 1'b0};
            n_st[k].rem_s = ss[DEN_W-1:0];
            n_st[k].q_s   = {s_src[k].q_s[W-2:0], ss[DEN_W]};
            n_st[k].low_s = {s_src[k].low_s[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[Q_W-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < Q_W; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // gray pixels divide by zero; their quotients are dropped here
    assign o_valid          = r_vld[Q_W-1];
    assign o_hsv.hue        = r_st[Q_W-1].gray ? '0 : r_st[Q_W-1].q_h;
    assign o_hsv.saturation = r_st[Q_W-1].gray ? '0 : r_st[Q_W-1].q_s;
    assign o_hsv.brightness = r_st[Q_W-1].value;

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_vld))
        else $error("divider valid bits moved during stall");
`endif

endmodule

[src/rgb_to_hsv_converter_core.sv]
// Top level of the RGB to HSV converter: front end, divider and output register.
//
// Usage:
//   Input channel: i_valid / o_ready with one RGB pixel on i_pixel per beat.
//   Output channel: o_valid / i_ready with hue, saturation and brightness on
//   o_hsv per beat. Every input beat yields exactly one output beat, in order.
//   Throughput is one pixel per clock: the pipeline takes a beat in every
//   cycle in which the output register is empty or is being taken.
//   From the accepting edge to o_valid a pixel passes through five front-end
//   stages (max/min, chroma and sector, hue offset, wrap, operands), sixteen
//   divider stages (one quotient bit each for the hue and saturation lanes)
//   and the output register.
//   When the receiver holds i_ready low with a result waiting, the whole
//   pipeline freezes and o_ready drops in the same cycle; nothing is lost or
//   repeated, and bubbles in flight stay in place.
//   Synchronous active-low reset empties every stage; no result is pending
//   after reset and the block is ready at once.
module rgb_to_hsv_converter_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rhsv_pkg::t_rgb i_pixel,
    output logic           o_valid,
    input  logic           i_ready,
    output rhsv_pkg::t_hsv o_hsv
);
    import rhsv_pkg::*;

    logic    s_en;
    logic    s_f_vld;
    t_div_in s_f_div;
    logic    s_d_vld;
    t_hsv    s_d_hsv;
    logic    r_out_valid;
    t_hsv    r_out;

    assign s_en    = !r_out_valid || i_ready;
    assign o_ready = s_en;

    rhsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_valid (i_valid),
        .i_pix   (i_pixel),
        .o_valid (s_f_vld),
        .o_div   (s_f_div)
    );

    rhsv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_valid (s_f_vld),
        .i_div   (s_f_div),
        .o_valid (s_d_vld),
        .o_hsv   (s_d_hsv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_en) begin
            r_out_valid <= s_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_out <= s_d_hsv;
        end
    end

    assign o_valid = r_out_valid;
    assign o_hsv   = r_out;

`ifndef SYNTHESIS
    a_hue_below_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hsv.hue != {CHANNEL_BITS{1'b1}}))
        else $error("hue reached a full turn");
    a_hue_needs_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hsv.hue != '0) |-> (o_hsv.saturation != '0))
        else $error("nonzero hue on a gray pixel");
    a_sat_needs_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hsv.saturation != '0) |-> (o_hsv.brightness != '0))
        else $error("saturation without brightness");
`endif

endmodule

[tb/tb.sv]
// Testbench for rgb_to_hsv_converter_core: random-handshake stimulus checked against an HSV predictor.
`timescale 1ns / 100ps

module tb;
    import rhsv_pkg::*;

    localparam logic [CHANNEL_BITS-1:0] FULL_SCALE = '1;
    localparam int RANDOM_PIXELS  = 1330;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AT_RESULT = 300;
    localparam int DRAIN_AT_PIXEL = 700;
    localparam int TAIL_CYCLES    = 40;
    localparam int STALL_LIMIT    = 2000;

    typedef struct {
        t_rgb px;
        bit   after_drain;  // hold this pixel back until every result is in
    } t_pending;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_rgb i_pixel = '0;
    logic o_ready;
    logic o_valid;
    t_hsv o_hsv;

    t_pending pixel_q[$];
    t_hsv     hsv_expect_q[$];

    int mismatches  = 0;
    int n_seen      = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    int idle_cycles = 0;
    bit tx_calm     = 1'b0;
    bit rx_calm     = 1'b0;
    t_hsv want;

    rgb_to_hsv_converter_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pixel (i_pixel),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_hsv   (o_hsv)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Value is the max channel, saturation chroma/value, hue the sector offset over 6*chroma.
    function automatic t_hsv hsv_of(t_rgb px);
        logic [CHANNEL_BITS-1:0] vmax;
        logic [CHANNEL_BITS-1:0] vmin;
        logic [CHANNEL_BITS-1:0] chroma;
        logic [NUM_W-1:0]        hue_num;
        logic [NUM_W-1:0]        sat_num;
        logic [DEN_W-1:0]        hue_den;
        int                      t;
        t_hsv                    res;
        vmax = px.red;
        if (px.green > vmax) vmax = px.green;
        if (px.blue > vmax) vmax = px.blue;
        vmin = px.red;
        if (px.green < vmin) vmin = px.green;
        if (px.blue < vmin) vmin = px.blue;
        chroma = vmax - vmin;
        res = '0;
        res.brightness = vmax;
        if (chroma != 0) begin
            // sector picked by first channel equal to the max: red, then green, then blue
            if (px.red == vmax) begin
                t = int'(px.green) - int'(px.blue);
            end else if (px.green == vmax) begin
                t = 2 * int'(chroma) + int'(px.blue) - int'(px.red);
            end else begin
                t = 4 * int'(chroma) + int'(px.red) - int'(px.green);
            end
            if (t < 0) t = t + 6 * int'(chroma);
            hue_den = DEN_W'(6 * int'(chroma));
            hue_num = NUM_W'(t) * NUM_W'(FULL_SCALE);
            sat_num = NUM_W'(chroma) * NUM_W'(FULL_SCALE);
            res.hue = Q_W'(hue_num / NUM_W'(hue_den));
            res.saturation = Q_W'(sat_num / NUM_W'(vmax));
        end
        return res;
    endfunction

    function automatic logic [CHANNEL_BITS-1:0] edge_channel();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return FULL_SCALE;
            2: return CHANNEL_BITS'(1) << $urandom_range(0, CHANNEL_BITS - 1);
            default: return CHANNEL_BITS'($urandom);
        endcase
    endfunction

    function automatic t_rgb random_pixel();
        t_rgb                    px;
        logic [CHANNEL_BITS-1:0] v;
        logic [CHANNEL_BITS-1:0] w;
        v = CHANNEL_BITS'($urandom);
        w = CHANNEL_BITS'($urandom);
        case ($urandom_range(0, 4))
            0: begin
                px = '{red: v, green: w, blue: CHANNEL_BITS'($urandom)};
            end
            1: begin
                // near gray: tiny chroma stresses the hue divider
                px.red   = v ^ CHANNEL_BITS'($urandom_range(0, 3));
                px.green = v ^ CHANNEL_BITS'($urandom_range(0, 3));
                px.blue  = v ^ CHANNEL_BITS'($urandom_range(0, 3));
            end
            2: begin
                // two channels tied, exercises the sector priority
                case ($urandom_range(0, 2))
                    0: px = '{red: v, green: v, blue: w};
                    1: px = '{red: w, green: v, blue: v};
                    default: px = '{red: v, green: w, blue: v};
                endcase
            end
            3: begin
                px = '{red: edge_channel(), green: edge_channel(), blue: edge_channel()};
            end
            default: begin
                px = '{red: v >> $urandom_range(0, 15), green: w >> $urandom_range(0, 15),
                       blue: CHANNEL_BITS'($urandom) >> $urandom_range(0, 15)};
            end
        endcase
        return px;
    endfunction

    task automatic add_pixel(input logic [CHANNEL_BITS-1:0] r, input logic [CHANNEL_BITS-1:0] g,
                             input logic [CHANNEL_BITS-1:0] b);
        pixel_q.push_back('{px: '{red: r, green: g, blue: b}, after_drain: 1'b0});
    endtask

    // driver: one beat per free slot, random gap after each pixel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                hsv_expect_q.push_back(hsv_of(i_pixel));
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pixel_q.size() == 0 ||
                             (pixel_q[0].after_drain && hsv_expect_q.size() != 0)) begin
                    i_valid <= 1'b0;
                end else begin
                    i_pixel <= pixel_q[0].px;
                    i_valid <= 1'b1;
                    void'(pixel_q.pop_front());
                    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
                    gap_left = tx_calm ? 0 : $urandom_range(0, 9);
                end
            end
        end
    end

    // monitor: checks each result beat and drives the receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (o_valid && i_ready) begin
            if (hsv_expect_q.size() == 0) begin
                $error("result beat with no pixel pending: hsv %h", o_hsv);
                mismatches++;
            end else begin
                want = hsv_expect_q.pop_front();
                if (o_hsv.hue !== want.hue) begin
                    $error("hue: expected %0d, got %0d", want.hue, o_hsv.hue);
                    mismatches++;
                end
                if (o_hsv.saturation !== want.saturation) begin
                    $error("saturation: expected %0d, got %0d", want.saturation,
                           o_hsv.saturation);
                    mismatches++;
                end
                if (o_hsv.brightness !== want.brightness) begin
                    $error("brightness: expected %0d, got %0d", want.brightness,
                           o_hsv.brightness);
                    mismatches++;
                end
            end
            n_seen++;
            if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
            // one long hold lets the pipeline fill and push back on the input
            stall_left = (n_seen == HOLD_AT_RESULT) ? LONG_HOLD :
                         (rx_calm ? 0 : $urandom_range(0, 9));
            if (stall_left > 0) i_ready <= 1'b0;
        end else if (!i_ready) begin
            if (stall_left > 0) stall_left--;
            else i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        // black, white, gray
        add_pixel(16'h0000, 16'h0000, 16'h0000);
        add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_pixel(16'h8000, 16'h8000, 16'h8000);
        // primaries and secondaries
        add_pixel(16'hFFFF, 16'h0000, 16'h0000);
        add_pixel(16'h0000, 16'hFFFF, 16'h0000);
        add_pixel(16'h0000, 16'h0000, 16'hFFFF);
        add_pixel(16'hFFFF, 16'hFFFF, 16'h0000);
        add_pixel(16'h0000, 16'hFFFF, 16'hFFFF);
        add_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
        // red max with blue above green: negative offset wraps; then small, near-full and mixed pixels
        add_pixel(16'hFFFF, 16'h0000, 16'h0001);
        add_pixel(16'h0001, 16'h0000, 16'h0000);
        add_pixel(16'h0000, 16'h0001, 16'h0000);
        add_pixel(16'h0000, 16'h0000, 16'h0001);
        add_pixel(16'hFFFF, 16'hFFFE, 16'hFFFF);
        add_pixel(16'hFFFE, 16'hFFFF, 16'hFFFE);
        add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFE);
        add_pixel(16'h5555, 16'hAAAA, 16'h5555);
        add_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
        add_pixel(16'h1234, 16'h5678, 16'h9ABC);
        add_pixel(16'hFEDC, 16'h0123, 16'h8001);
        add_pixel(16'h0001, 16'h0001, 16'h0002);
        add_pixel(16'h7FFF, 16'h8000, 16'h7FFF);
        for (int k = 0; k < RANDOM_PIXELS; k++) begin
            pixel_q.push_back('{px: random_pixel(),
                                after_drain: (k == 0 || k == DRAIN_AT_PIXEL)});
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        while (pixel_q.size() != 0 || i_valid || hsv_expect_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
